FILE: hw/rtl/sit_pkg.sv
// Shared types and widths for the segment intersection test.
// Used by sit_orient and segment_intersection_test; depends on nothing.
`default_nettype none

package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  // Latency of the orientation unit in register stages
  localparam int ORIENT_STAGES = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  // Sign of a cross product; both low means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sit_sign_t;

  // Point and box relations found in the first stage
  typedef struct packed {
    logic meet_pt;  // some endpoint of one segment equals one of the other
    logic p_zero;   // first segment has zero length
    logic q_zero;   // second segment has zero length
    logic p1_in_q;  // first start lies in the box of the second segment
    logic p2_in_q;
    logic q1_in_p;  // second start lies in the box of the first segment
    logic q2_in_p;
  } sit_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sit_orient.sv
// Pipelined orientation sign of cross(b - a, c - a): differences, products, sign.
// Depends on sit_pkg.
`default_nettype none

module sit_orient
  import sit_pkg::*;
(
  input  wire logic      clk,
  input  wire coord_t    a_x,
  input  wire coord_t    a_y,
  input  wire coord_t    b_x,
  input  wire coord_t    b_y,
  input  wire coord_t    c_x,
  input  wire coord_t    c_y,
  output sit_sign_t      sign_out
);

  diff_t     ux_r, uy_r, vx_r, vy_r;
  diff_t     ux_nxt, uy_nxt, vx_nxt, vy_nxt;
  prod_t     p0_r, p1_r, p0_nxt, p1_nxt;
  cross_t    cross_sum;
  sit_sign_t sign_r, sign_nxt;

  always_comb begin
    ux_nxt = DIFF_BITS'(b_x) - DIFF_BITS'(a_x);
    uy_nxt = DIFF_BITS'(b_y) - DIFF_BITS'(a_y);
    vx_nxt = DIFF_BITS'(c_x) - DIFF_BITS'(a_x);
    vy_nxt = DIFF_BITS'(c_y) - DIFF_BITS'(a_y);
    p0_nxt = ux_r * vy_r;
    p1_nxt = uy_r * vx_r;
    cross_sum    = CROSS_BITS'(p0_r) - CROSS_BITS'(p1_r);
    sign_nxt.neg = cross_sum[CROSS_BITS-1];
    sign_nxt.pos = !cross_sum[CROSS_BITS-1] && (cross_sum != '0);
  end

  always_ff @(posedge clk) begin
    ux_r   <= ux_nxt;
    uy_r   <= uy_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    sign_r <= sign_nxt;
  end

  assign sign_out = sign_r;

endmodule

`default_nettype wire

FILE: hw/rtl/segment_intersection_test.sv
// Top level of the 2D closed segment intersection test.
// Depends on sit_pkg and sit_orient.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+--------------------------
//   request | in_first_*, in_second_* (signed coords) | start high, busy low
//   result  | out_segments_meet                       | out_valid strobe, 1 cycle
//
// A request enters every cycle; its result passes the three stages of the orientation
// units and then one decision stage, and comes out registered together with out_valid.
// busy stays low: nothing holds the pipeline, since the receiver cannot stall.
// rst_n (synchronous) clears only the valid bits; data registers are not reset.
`default_nettype none

module segment_intersection_test
  import sit_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  output logic        busy,
  input  wire coord_t in_first_start_x,
  input  wire coord_t in_first_start_y,
  input  wire coord_t in_first_end_x,
  input  wire coord_t in_first_end_y,
  input  wire coord_t in_second_start_x,
  input  wire coord_t in_second_start_y,
  input  wire coord_t in_second_end_x,
  input  wire coord_t in_second_end_y,
  output logic        out_valid,
  output logic        out_segments_meet
);

  // Point relations between an endpoint of each segment
  logic       ge_x11, le_x11, ge_y11, le_y11;
  logic       ge_x12, le_x12, ge_y12, le_y12;
  logic       ge_x21, le_x21, ge_y21, le_y21;
  logic       ge_x22, le_x22, ge_y22, le_y22;

  sit_flags_t flags_nxt;
  sit_flags_t flags_r [ORIENT_STAGES];
  logic [ORIENT_STAGES-1:0] valid_r;
  sit_sign_t  d1, d2, d3, d4;
  logic       z1, z2, z3, z4;
  logic       meet_nxt;
  logic       out_valid_r, out_meet_r;
  sit_flags_t fl;

  assign busy = 1'b0;

  always_comb begin
    ge_x11 = in_first_start_x >= in_second_start_x;
    le_x11 = in_first_start_x <= in_second_start_x;
    ge_y11 = in_first_start_y >= in_second_start_y;
    le_y11 = in_first_start_y <= in_second_start_y;
    ge_x12 = in_first_start_x >= in_second_end_x;
    le_x12 = in_first_start_x <= in_second_end_x;
    ge_y12 = in_first_start_y >= in_second_end_y;
    le_y12 = in_first_start_y <= in_second_end_y;
    ge_x21 = in_first_end_x >= in_second_start_x;
    le_x21 = in_first_end_x <= in_second_start_x;
    ge_y21 = in_first_end_y >= in_second_start_y;
    le_y21 = in_first_end_y <= in_second_start_y;
    ge_x22 = in_first_end_x >= in_second_end_x;
    le_x22 = in_first_end_x <= in_second_end_x;
    ge_y22 = in_first_end_y >= in_second_end_y;
    le_y22 = in_first_end_y <= in_second_end_y;

    flags_nxt.meet_pt = (ge_x11 && le_x11 && ge_y11 && le_y11) ||
                        (ge_x12 && le_x12 && ge_y12 && le_y12) ||
                        (ge_x21 && le_x21 && ge_y21 && le_y21) ||
                        (ge_x22 && le_x22 && ge_y22 && le_y22);
    flags_nxt.p_zero = (in_first_start_x == in_first_end_x) &&
                       (in_first_start_y == in_first_end_y);
    flags_nxt.q_zero = (in_second_start_x == in_second_end_x) &&
                       (in_second_start_y == in_second_end_y);
    flags_nxt.p1_in_q = ((ge_x11 && le_x12) || (ge_x12 && le_x11)) &&
                        ((ge_y11 && le_y12) || (ge_y12 && le_y11));
    flags_nxt.p2_in_q = ((ge_x21 && le_x22) || (ge_x22 && le_x21)) &&
                        ((ge_y21 && le_y22) || (ge_y22 && le_y21));
    flags_nxt.q1_in_p = ((le_x11 && ge_x21) || (le_x21 && ge_x11)) &&
                        ((le_y11 && ge_y21) || (le_y21 && ge_y11));
    flags_nxt.q2_in_p = ((le_x12 && ge_x22) || (le_x22 && ge_x12)) &&
                        ((le_y12 && ge_y22) || (le_y22 && ge_y12));
  end

  sit_orient u_orient_d1 (
    .clk(clk),
    .a_x(in_first_start_x), .a_y(in_first_start_y),
    .b_x(in_first_end_x),   .b_y(in_first_end_y),
    .c_x(in_second_start_x), .c_y(in_second_start_y),
    .sign_out(d1)
  );

  sit_orient u_orient_d2 (
    .clk(clk),
    .a_x(in_first_start_x), .a_y(in_first_start_y),
    .b_x(in_first_end_x),   .b_y(in_first_end_y),
    .c_x(in_second_end_x),  .c_y(in_second_end_y),
    .sign_out(d2)
  );

  sit_orient u_orient_d3 (
    .clk(clk),
    .a_x(in_second_start_x), .a_y(in_second_start_y),
    .b_x(in_second_end_x),   .b_y(in_second_end_y),
    .c_x(in_first_start_x),  .c_y(in_first_start_y),
    .sign_out(d3)
  );

  sit_orient u_orient_d4 (
    .clk(clk),
    .a_x(in_second_start_x), .a_y(in_second_start_y),
    .b_x(in_second_end_x),   .b_y(in_second_end_y),
    .c_x(in_first_end_x),    .c_y(in_first_end_y),
    .sign_out(d4)
  );

  // Carry the flags alongside the orientation pipeline
  always_ff @(posedge clk) begin
    flags_r[0] <= flags_nxt;
    for (int i = 1; i < ORIENT_STAGES; i++) begin
      flags_r[i] <= flags_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= {valid_r[ORIENT_STAGES-2:0], start && !busy};
      out_valid_r <= valid_r[ORIENT_STAGES-1];
    end
  end

  always_comb begin
    fl = flags_r[ORIENT_STAGES-1];
    z1 = !d1.pos && !d1.neg;
    z2 = !d2.pos && !d2.neg;
    z3 = !d3.pos && !d3.neg;
    z4 = !d4.pos && !d4.neg;
    if (fl.meet_pt) begin
      meet_nxt = 1'b1;
    end else if (fl.p_zero) begin
      meet_nxt = z3 && fl.p1_in_q;
    end else if (fl.q_zero) begin
      meet_nxt = z1 && fl.q1_in_p;
    end else if (z1 && z2) begin
      // Collinear: meet when any endpoint lies on the other segment
      meet_nxt = (z1 && fl.q1_in_p) || (z2 && fl.q2_in_p) ||
                 (z3 && fl.p1_in_q) || (z4 && fl.p2_in_q);
    end else begin
      meet_nxt = !((d1.pos && d2.pos) || (d1.neg && d2.neg) ||
                   (d3.pos && d4.pos) || (d3.neg && d4.neg));
    end
  end

  always_ff @(posedge clk) begin
    out_meet_r <= meet_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_segments_meet = out_meet_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, ORIENT_STAGES + 1))
    else $error("result strobe without a request four cycles earlier");

  a_shared_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ORIENT_STAGES-1] && fl.meet_pt |=> out_segments_meet)
    else $error("shared endpoint not reported as meeting");

  a_two_points: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ORIENT_STAGES-1] && fl.p_zero && fl.q_zero && !fl.meet_pt
      |=> !out_segments_meet)
    else $error("distinct zero-length segments reported as meeting");

  a_degenerate_zero_cross: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ORIENT_STAGES-1] && fl.q_zero |-> z3 && z4)
    else $error("cross product against a zero-length segment is not zero");
`endif

endmodule

`default_nettype wire
